[src/assert_macros.svh]
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define MEP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define MEP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define MEP_ASSERT(lbl, clk, rst_n, prop)
`define MEP_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[src/mep_pkg.sv]
package mep_pkg;

  localparam int unsigned BitmapBytesDef = 8000;
  localparam int unsigned AttrCellsDef   = 1000;
  localparam int unsigned ScrW           = 160;
  localparam int unsigned ScrH           = 200;
  localparam int unsigned RowBytes       = 320;
  localparam int unsigned CellsPerRow    = 40;
  localparam logic [3:0]  NibbleMask     = 4'h0F;
  localparam logic [3:0]  RadiusXRst     = 4'd3;
  localparam logic [3:0]  RadiusYRst     = 4'd4;

  typedef enum logic [1:0] {
    REGION_BITMAP = 2'd0,
    REGION_SCREEN = 2'd1,
    REGION_COLOUR = 2'd2,
    REGION_NONE   = 2'd3
  } region_e;

  typedef enum logic {
    FUNC_DRAW = 1'b0,
    FUNC_READ = 1'b1
  } func_e;

  typedef enum logic {
    CFG_RADIUS_X = 1'b0,
    CFG_RADIUS_Y = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PAT_NONE = 2'd0,
    PAT_HI   = 2'd1,
    PAT_LO   = 2'd2,
    PAT_CS   = 2'd3
  } pat_e;

  typedef struct packed {
    logic rd_en;
    logic bm_we;
    logic attr_we;
    logic col_we;
  } store_ctl_t;

endpackage

[src/mep_span.sv]
module mep_span (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic signed [4:0] dy_i,
  input  logic [3:0]        radius_x_i,
  input  logic [3:0]        radius_y_i,
  output logic              done_o,
  output logic [3:0]        width_o
);
  import mep_pkg::*;

  localparam logic [1:0] SP_IDLE = 2'd0;
  localparam logic [1:0] SP_SQ   = 2'd1;
  localparam logic [1:0] SP_T    = 2'd2;
  localparam logic [1:0] SP_SRCH = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [3:0]  mag_q;
  logic [7:0]  dy2_q, rx2_q, ry2_q;
  logic [15:0] t_q;
  logic [3:0]  w_q;
  logic [8:0]  sq_q;
  logic [16:0] prod;
  logic        grow;

  assign prod    = 17'(sq_q) * 17'(ry2_q);
  assign grow    = (w_q < radius_x_i) && ({1'b0, t_q} >= prod);
  assign done_o  = (state_q == SP_SRCH) && !grow;
  assign width_o = w_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SP_IDLE: if (start_i) state_d = SP_SQ;
      SP_SQ:   state_d = SP_T;
      SP_T:    state_d = SP_SRCH;
      SP_SRCH: if (!grow) state_d = SP_IDLE;
      default: state_d = SP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SP_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && state_q == SP_IDLE) begin
      mag_q <= dy_i[4] ? 4'(-dy_i) : dy_i[3:0];
    end
    if (state_q == SP_SQ) begin
      dy2_q <= mag_q * mag_q;
      rx2_q <= radius_x_i * radius_x_i;
      ry2_q <= radius_y_i * radius_y_i;
    end
    if (state_q == SP_T) begin
      t_q  <= 16'(rx2_q) * 16'(ry2_q - dy2_q);
      w_q  <= '0;
      sq_q <= 9'd1;
    end
    if (state_q == SP_SRCH && grow) begin
      w_q  <= w_q + 4'd1;
      sq_q <= 9'(sq_q + {4'd0, w_q, 1'b0} + 9'd3);
    end
  end

endmodule

[src/mep_store.sv]
module mep_store #(
  parameter int unsigned BmDepth   = mep_pkg::BitmapBytesDef,
  parameter int unsigned CellDepth = mep_pkg::AttrCellsDef,
  localparam int BmAw   = $clog2(BmDepth),
  localparam int CellAw = $clog2(CellDepth)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mep_pkg::store_ctl_t ctl_i,
  input  logic [BmAw-1:0]     bm_addr_i,
  input  logic [CellAw-1:0]   cell_addr_i,
  input  logic [7:0]          bm_wdata_i,
  input  logic [7:0]          attr_wdata_i,
  input  logic [3:0]          col_wdata_i,
  output logic [7:0]          bm_rdata_o,
  output logic [7:0]          attr_rdata_o,
  output logic [3:0]          col_rdata_o,
  output logic                busy_o
);
  import mep_pkg::*;

  logic [7:0] bm_mem   [BmDepth];
  logic [7:0] attr_mem [CellDepth];
  logic [3:0] col_mem  [CellDepth];

  logic            busy_q;
  logic [BmAw-1:0] cnt_q;
  logic            cnt_last, cnt_cell;
  logic [BmAw-1:0]   bm_wa;
  logic [CellAw-1:0] cell_wa;

  assign busy_o   = busy_q;
  assign cnt_last = (32'(cnt_q) == BmDepth - 1);
  assign cnt_cell = (32'(cnt_q) < CellDepth);
  assign bm_wa    = busy_q ? cnt_q : bm_addr_i;
  assign cell_wa  = busy_q ? cnt_q[CellAw-1:0] : cell_addr_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_last) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q || ctl_i.bm_we) bm_mem[bm_wa] <= busy_q ? 8'd0 : bm_wdata_i;
    if ((busy_q && cnt_cell) || (!busy_q && ctl_i.attr_we)) begin
      attr_mem[cell_wa] <= busy_q ? 8'd0 : attr_wdata_i;
    end
    if ((busy_q && cnt_cell) || (!busy_q && ctl_i.col_we)) begin
      col_mem[cell_wa] <= busy_q ? 4'd0 : col_wdata_i;
    end
    if (ctl_i.rd_en) begin
      bm_rdata_o   <= bm_mem[bm_addr_i];
      attr_rdata_o <= attr_mem[cell_addr_i];
      col_rdata_o  <= col_mem[cell_addr_i];
    end
  end

endmodule

[src/multicolour_ellipse_plotter.sv]
// Filled-ellipse plotter for a 160x200 multicolour bitmap with 4x8 attribute
// cells. After reset the stores are cleared, one bitmap byte per cycle,
// during which no item is taken. A read issues the store read, then registers
// the byte once the output is free. A draw, per scanline, first searches the
// half-width (one compare a cycle), then reads and writes back each on-screen
// pixel through the single read-modify-write port of the stores and steps past
// each clipped pixel. Radii are to be written only while idle; the block itself does not enforce this.
module multicolour_ellipse_plotter #(
  parameter int unsigned BITMAP_BYTES    = mep_pkg::BitmapBytesDef,
  parameter int unsigned ATTRIBUTE_CELLS = mep_pkg::AttrCellsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_index_i,
  input  logic [3:0]        cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              func_i,
  input  logic signed [8:0] centre_x_i,
  input  logic signed [8:0] centre_y_i,
  input  logic [3:0]        ball_colour_i,
  input  logic [1:0]        region_i,
  input  logic [12:0]       read_address_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        read_data_o,
  output logic              address_error_o
);
  import mep_pkg::*;
`include "assert_macros.svh"

  localparam int BmAw   = $clog2(BITMAP_BYTES);
  localparam int CellAw = $clog2(ATTRIBUTE_CELLS);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_RD_ISS = 4'd1;
  localparam logic [3:0] ST_RD_DAT = 4'd2;
  localparam logic [3:0] ST_ROW    = 4'd3;
  localparam logic [3:0] ST_SEARCH = 4'd4;
  localparam logic [3:0] ST_PIX    = 4'd5;
  localparam logic [3:0] ST_PIX_WR = 4'd6;
  localparam logic [3:0] ST_FINISH = 4'd7;

  logic [3:0] state_q, state_d;
  logic [3:0] rx_q, ry_q;
  logic signed [8:0] cx_q, cy_q;
  logic [3:0]  col_q;
  logic [1:0]  region_q;
  logic [12:0] addr_q;
  logic signed [4:0] dy_q, dx_q;
  logic [3:0]  w_q;
  logic [BmAw-1:0]   bm_addr_q;
  logic [CellAw-1:0] cell_addr_q;
  logic [1:0]  px_lo_q;
  logic        out_valid_q;
  logic [7:0]  data_q;
  logic        err_q;

  logic              span_start, span_done;
  logic [3:0]        span_w;
  store_ctl_t        ctl;
  logic [BmAw-1:0]   bm_addr, bm_addr_c;
  logic [CellAw-1:0] cell_addr, cell_addr_c;
  logic [7:0]  bm_rdata, attr_rdata, bm_wdata, attr_wdata;
  logic [3:0]  col_rdata, col_wdata;
  logic        busy, out_free, rd_ok, on_screen, row_end, last_row;
  logic signed [9:0] px, py;
  logic [7:0]  rd_sel;
  logic [3:0]  hi, lo, cs;
  logic [1:0]  pat;
  logic [2:0]  sh;
  logic        attr_we, col_we;

  assign cfg_ready_o     = 1'b1;
  assign in_ready_o      = (state_q == ST_IDLE) && !busy;
  assign out_valid_o     = out_valid_q;
  assign read_data_o     = data_q;
  assign address_error_o = err_q;
  assign out_free        = !out_valid_q || out_ready_i;

  always_comb begin
    unique case (region_q)
      REGION_BITMAP: rd_ok = 32'(addr_q) < BITMAP_BYTES;
      REGION_SCREEN,
      REGION_COLOUR: rd_ok = 32'(addr_q) < ATTRIBUTE_CELLS;
      default:       rd_ok = 1'b0;
    endcase
  end

  always_comb begin
    case (region_q)
      REGION_BITMAP: rd_sel = bm_rdata;
      REGION_SCREEN: rd_sel = attr_rdata;
      default:       rd_sel = {4'd0, col_rdata & NibbleMask};
    endcase
  end

  assign px = 10'(cx_q) + 10'(dx_q);
  assign py = 10'(cy_q) + 10'(dy_q);
  assign on_screen = !px[9] && !py[9] && (32'(px) < ScrW) && (32'(py) < ScrH);
  assign cell_addr_c = CellAw'(32'(py[7:3]) * CellsPerRow + 32'(px[7:2]));
  assign bm_addr_c   = BmAw'(32'(py[7:3]) * RowBytes + 32'(px[7:2]) * 8 + 32'(py[2:0]));
  assign row_end  = (dx_q == $signed({1'b0, w_q}));
  assign last_row = (dy_q == $signed({1'b0, ry_q}));

  always_comb begin
    bm_addr   = bm_addr_q;
    cell_addr = cell_addr_q;
    if (state_q == ST_PIX) begin
      bm_addr   = bm_addr_c;
      cell_addr = cell_addr_c;
    end else if (state_q == ST_RD_ISS) begin
      bm_addr   = BmAw'(addr_q);
      cell_addr = CellAw'(addr_q);
    end
  end

  always_comb begin
    hi = attr_rdata[7:4];
    lo = attr_rdata[3:0];
    cs = col_rdata & NibbleMask;
    attr_we    = 1'b0;
    col_we     = 1'b0;
    attr_wdata = attr_rdata;
    col_wdata  = col_q;
    if (hi == col_q) begin
      pat = PAT_HI;
    end else if (lo == col_q) begin
      pat = PAT_LO;
    end else if (cs == col_q) begin
      pat = PAT_CS;
    end else if (hi == 4'd0) begin
      pat = PAT_HI; attr_we = 1'b1; attr_wdata = {col_q, lo};
    end else if (lo == 4'd0) begin
      pat = PAT_LO; attr_we = 1'b1; attr_wdata = {hi, col_q};
    end else if (cs == 4'd0) begin
      pat = PAT_CS; col_we = 1'b1;
    end else begin
      pat = PAT_HI;
    end
    sh = {2'd3 - px_lo_q, 1'b0};
    bm_wdata = (bm_rdata & ~(8'd3 << sh)) | (8'(pat) << sh);
  end

  always_comb begin
    ctl         = '0;
    span_start  = 1'b0;
    state_d     = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          state_d = (func_i == FUNC_READ) ? ST_RD_ISS : ST_ROW;
        end
      end
      ST_RD_ISS: begin
        ctl.rd_en = rd_ok;
        state_d   = ST_RD_DAT;
      end
      ST_RD_DAT: if (out_free) state_d = ST_IDLE;
      ST_ROW: begin
        span_start = 1'b1;
        state_d    = ST_SEARCH;
      end
      ST_SEARCH: if (span_done) state_d = ST_PIX;
      ST_PIX: begin
        if (on_screen) begin
          ctl.rd_en = 1'b1;
          state_d   = ST_PIX_WR;
        end else if (row_end) begin
          state_d = last_row ? ST_FINISH : ST_ROW;
        end
      end
      ST_PIX_WR: begin
        ctl.bm_we   = 1'b1;
        ctl.attr_we = attr_we;
        ctl.col_we  = col_we;
        state_d = row_end ? (last_row ? ST_FINISH : ST_ROW) : ST_PIX;
      end
      ST_FINISH: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rx_q        <= RadiusXRst;
      ry_q        <= RadiusYRst;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_RADIUS_X) rx_q <= cfg_data_i;
        else ry_q <= cfg_data_i;
      end
      if ((state_q == ST_RD_DAT || state_q == ST_FINISH) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cx_q     <= centre_x_i;
      cy_q     <= centre_y_i;
      col_q    <= ball_colour_i;
      region_q <= region_i;
      addr_q   <= read_address_i;
      dy_q     <= 5'(-$signed({1'b0, ry_q}));
    end
    if (state_q == ST_SEARCH && span_done) begin
      w_q  <= span_w;
      dx_q <= 5'(-$signed({1'b0, span_w}));
    end
    if (state_q == ST_PIX && on_screen) begin
      bm_addr_q   <= bm_addr_c;
      cell_addr_q <= cell_addr_c;
      px_lo_q     <= px[1:0];
    end
    if ((state_q == ST_PIX && !on_screen) || state_q == ST_PIX_WR) begin
      if (row_end) dy_q <= dy_q + 5'sd1;
      else dx_q <= dx_q + 5'sd1;
    end
    if (state_q == ST_RD_DAT && out_free) begin
      data_q <= rd_ok ? rd_sel : 8'd0;
      err_q  <= !rd_ok;
    end
    if (state_q == ST_FINISH && out_free) begin
      data_q <= 8'd0;
      err_q  <= 1'b0;
    end
  end

  mep_span u_span (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (span_start),
    .dy_i       (dy_q),
    .radius_x_i (rx_q),
    .radius_y_i (ry_q),
    .done_o     (span_done),
    .width_o    (span_w)
  );

  mep_store #(
    .BmDepth   (BITMAP_BYTES),
    .CellDepth (ATTRIBUTE_CELLS)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .bm_addr_i    (bm_addr),
    .cell_addr_i  (cell_addr),
    .bm_wdata_i   (bm_wdata),
    .attr_wdata_i (attr_wdata),
    .col_wdata_i  (col_wdata),
    .bm_rdata_o   (bm_rdata),
    .attr_rdata_o (attr_rdata),
    .col_rdata_o  (col_rdata),
    .busy_o       (busy)
  );

  `MEP_ASSERT(a_no_accept_in_clear, clk_i, rst_ni, in_ready_o |-> !busy)
  `MEP_ASSERT(a_err_zero_data, clk_i, rst_ni, (out_valid_o && address_error_o) |-> (read_data_o == 8'd0))
  `MEP_ASSERT(a_wr_after_rd, clk_i, rst_ni, (state_q == ST_PIX_WR) |-> ($past(state_q) == ST_PIX))

endmodule

[tb/multicolour_ellipse_plotter_tb.sv]
module multicolour_ellipse_plotter_tb;
  import mep_pkg::*;

  localparam int unsigned StallLimit = 60000;

  typedef struct packed {
    logic [7:0] data;
    logic       err;
  } read_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic              cfg_index_i = CFG_RADIUS_X;
  logic [3:0]        cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic              func_i = FUNC_READ;
  logic signed [8:0] centre_x_i = '0;
  logic signed [8:0] centre_y_i = '0;
  logic [3:0]        ball_colour_i = '0;
  logic [1:0]        region_i = REGION_BITMAP;
  logic [12:0]       read_address_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [7:0]        read_data_o;
  logic              address_error_o;

  logic [7:0] bitmap_model [BitmapBytesDef];
  logic [7:0] screen_model [AttrCellsDef];
  logic [3:0] colour_model [AttrCellsDef];
  logic [3:0] rad_x;
  logic [3:0] rad_y;

  read_result_t expected_bytes [$];
  int unsigned  mismatches = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  hold_cnt = 0;
  int unsigned  ready_gap = 0;
  bit           long_hold_req = 1'b0;
  bit           no_idle = 1'b0;

  multicolour_ellipse_plotter DUT (.*);

  always #6 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, 2);
    if (r < 96) return $urandom_range(3, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic void plot_pixel(int x, int y, logic [3:0] col);
    int        cell_idx;
    int        off;
    int        sh;
    logic [3:0] hi;
    logic [3:0] lo;
    logic [3:0] cs;
    pat_e      pat;
    cell_idx = (y >> 3) * CellsPerRow + (x >> 2);
    off  = (y >> 3) * RowBytes + (x >> 2) * 8 + (y & 7);
    hi = screen_model[cell_idx][7:4];
    lo = screen_model[cell_idx][3:0];
    cs = colour_model[cell_idx];
    if (hi == col) pat = PAT_HI;
    else if (lo == col) pat = PAT_LO;
    else if (cs == col) pat = PAT_CS;
    else if (hi == 4'd0) begin
      screen_model[cell_idx] = {col, lo};
      pat = PAT_HI;
    end else if (lo == 4'd0) begin
      screen_model[cell_idx] = {hi, col};
      pat = PAT_LO;
    end else if (cs == 4'd0) begin
      colour_model[cell_idx] = col;
      pat = PAT_CS;
    end else pat = PAT_HI;
    sh = (3 - (x & 3)) * 2;
    bitmap_model[off] = (bitmap_model[off] & ~(8'd3 << sh)) | (8'(pat) << sh);
  endfunction

  function automatic void plot_ellipse(int cx, int cy, logic [3:0] col);
    int rx;
    int ry;
    int t;
    int w;
    int px;
    int py;
    rx = rad_x;
    ry = rad_y;
    for (int dy = -ry; dy <= ry; dy++) begin
      t = rx * rx * (ry * ry - dy * dy);
      w = 0;
      while (w < rx && (w + 1) * (w + 1) * ry * ry <= t) w++;
      for (int dx = -w; dx <= w; dx++) begin
        px = cx + dx;
        py = cy + dy;
        if (px >= 0 && px < ScrW && py >= 0 && py < ScrH) plot_pixel(px, py, col);
      end
    end
  endfunction

  function automatic read_result_t read_store(region_e reg_sel, int unsigned addr);
    read_result_t r;
    r = '0;
    if (reg_sel == REGION_BITMAP && addr < BitmapBytesDef) r.data = bitmap_model[addr];
    else if (reg_sel == REGION_SCREEN && addr < AttrCellsDef) r.data = screen_model[addr];
    else if (reg_sel == REGION_COLOUR && addr < AttrCellsDef) r.data = {4'd0, colour_model[addr]};
    else r.err = 1'b1;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d, want %0d", what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    read_result_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_RADIUS_X) rad_x = cfg_data_i;
        else rad_y = cfg_data_i;
      end
      if (in_valid_i && in_ready_o) begin
        if (func_i == FUNC_DRAW) begin
          plot_ellipse(int'(centre_x_i), int'(centre_y_i), ball_colour_i);
          expected_bytes.push_back('0);
        end else begin
          expected_bytes.push_back(read_store(region_e'(region_i), read_address_i));
        end
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = expected_bytes.pop_front();
          if (read_data_o !== want.data) report_mismatch("read_data", read_data_o, want.data);
          if (address_error_o !== want.err)
            report_mismatch("address_error", address_error_o, want.err);
        end
      end
      if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && in_ready_o) ||
          (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  always @(negedge clk_i) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready_i <= 1'b0;
    end else if (no_idle) begin
      out_ready_i <= 1'b1;
    end else if (ready_gap > 0) begin
      ready_gap--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 3) == 0) ready_gap = pick_gap();
    end
  end

  task automatic send_item(func_e f, int cx, int cy, int col, region_e rg, int addr);
    int unsigned gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    func_i         <= f;
    centre_x_i     <= 9'(cx);
    centre_y_i     <= 9'(cy);
    ball_colour_i  <= 4'(col);
    region_i       <= rg;
    read_address_i <= 13'(addr);
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_radius(cfg_idx_e idx, int val);
    drain();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= 4'(val);
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic read_around(int cx, int cy);
    int x;
    int y;
    x = (cx < 0) ? 0 : (cx > 159) ? 159 : cx;
    y = (cy < 0) ? 0 : (cy > 199) ? 199 : cy;
    send_item(FUNC_READ, 0, 0, 0, REGION_BITMAP, (y >> 3) * 320 + (x >> 2) * 8 + (y & 7));
    send_item(FUNC_READ, 0, 0, 0, REGION_SCREEN, (y >> 3) * 40 + (x >> 2));
    send_item(FUNC_READ, 0, 0, 0, REGION_COLOUR, (y >> 3) * 40 + (x >> 2));
  endtask

  task automatic test_store_bounds();
    send_item(FUNC_READ, 0, 0, 0, REGION_BITMAP, 0);
    send_item(FUNC_READ, 0, 0, 0, REGION_BITMAP, 7999);
    send_item(FUNC_READ, 0, 0, 0, REGION_BITMAP, 8000);
    send_item(FUNC_READ, 0, 0, 0, REGION_SCREEN, 999);
    send_item(FUNC_READ, 0, 0, 0, REGION_SCREEN, 1000);
    send_item(FUNC_READ, 0, 0, 0, REGION_COLOUR, 8191);
    send_item(FUNC_READ, 0, 0, 0, REGION_NONE, 5);
  endtask

  task automatic test_colour_clash();
    send_item(FUNC_DRAW, 2, 4, 0, REGION_NONE, 8191);
    for (int c = 1; c <= 5; c++) send_item(FUNC_DRAW, 2, 4, c, REGION_BITMAP, 0);
    send_item(FUNC_DRAW, 2, 4, 0, REGION_BITMAP, 0);
    read_around(2, 4);
  endtask

  task automatic test_radius_extremes();
    write_radius(CFG_RADIUS_Y, 0);
    write_radius(CFG_RADIUS_X, 15);
    send_item(FUNC_DRAW, 80, 100, 15, REGION_BITMAP, 0);
    read_around(70, 100);
    write_radius(CFG_RADIUS_Y, 15);
    send_item(FUNC_DRAW, -32, -32, 7, REGION_BITMAP, 0);
    send_item(FUNC_DRAW, 191, 231, 9, REGION_BITMAP, 0);
    read_around(159, 199);
    write_radius(CFG_RADIUS_X, 0);
    send_item(FUNC_DRAW, 0, 199, 12, REGION_BITMAP, 0);
    read_around(0, 199);
  endtask

  task automatic test_random(int unsigned n);
    int cx;
    int cy;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 120 == 0) begin
        write_radius(CFG_RADIUS_X, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                                : $urandom_range(0, 5));
        write_radius(CFG_RADIUS_Y, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                                : $urandom_range(0, 5));
        no_idle = ($urandom_range(0, 3) == 0);
      end
      cx = $urandom_range(0, 223) - 32;
      cy = $urandom_range(0, 263) - 32;
      if ($urandom_range(0, 1) == 0) begin
        send_item(FUNC_DRAW, cx, cy, $urandom_range(0, 15),
                  region_e'($urandom_range(0, 3)), $urandom_range(0, 8191));
        read_around(cx, cy);
        i += 3;
      end else begin
        send_item(FUNC_READ, cx, cy, $urandom_range(0, 15), region_e'($urandom_range(0, 3)),
                  ($urandom_range(0, 1) == 0) ? $urandom_range(0, 8191)
                                              : $urandom_range(0, 999));
      end
    end
    no_idle = 1'b0;
  endtask

  task automatic test_backpressure();
    drain();
    long_hold_req = 1'b1;
    for (int i = 0; i < 30; i++)
      send_item(FUNC_READ, 0, 0, 0, region_e'($urandom_range(0, 3)), $urandom_range(0, 8191));
  endtask

  initial begin
    for (int i = 0; i < BitmapBytesDef; i++) bitmap_model[i] = '0;
    for (int i = 0; i < AttrCellsDef; i++) begin
      screen_model[i] = '0;
      colour_model[i] = '0;
    end
    rad_x = RadiusXRst;
    rad_y = RadiusYRst;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_store_bounds();
    test_colour_clash();
    test_radius_extremes();
    test_backpressure();
    test_random(700);
    drain();
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && expected_bytes.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
